>>> hdl/multimodal_rope_position_generator_macros.svh
// Assertion macros shared by the position generator RTL.
`ifndef MULTIMODAL_ROPE_POSITION_GENERATOR_MACROS_SVH
`define MULTIMODAL_ROPE_POSITION_GENERATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MRPG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MRPG_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/mrpg_pkg.sv
// Types and constants of the multimodal rotary position generator.
package mrpg_pkg;

	localparam int MAX_TOKENS = 65536;

	localparam int TOKEN_W  = 31;
	localparam int COUNT_W  = 17;
	localparam int TEMP_W   = 16;
	localparam int NEXT_W   = 18;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 72;
	localparam int ADDR_W   = 4;

	typedef enum logic [1:0] {
		PH_BEFORE = 2'd0,
		PH_RUN    = 2'd1,
		PH_AFTER  = 2'd2,
		PH_PLAIN  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		REG_IMAGE_TOKEN   = 2'd0,
		REG_FEATURE_COUNT = 2'd1,
		REG_GRID_ROWS     = 2'd2,
		REG_GRID_COLS     = 2'd3
	} cfg_reg_t;

endpackage

>>> hdl/multimodal_rope_position_generator.sv
// A token accepted into the input register reaches the master side through the result register.
// Throughput: one token per cycle while m_tready stays high; the input register and the result
// register each take a new transaction while the one ahead moves on.
// The sequence counters update once per token as it moves into the result register.
// Reset (arst_n low, asynchronous) clears the valid flags, the configuration and the sequence state.
// Configuration registers take effect for the next token.
`include "multimodal_rope_position_generator_macros.svh"

module multimodal_rope_position_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_tdata: token_value [30:0], sequence_length [47:31].
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mrpg_pkg::S_DATA_W-1:0] s_tdata,
	// m_tdata: temporal_position [15:0], row_position [32:16],
	// column_position [49:33], next_pos [67:50], zero fill above.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mrpg_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tlast,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mrpg_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import mrpg_pkg::*;

	logic [TOKEN_W-1:0] image_token_q;
	logic [COUNT_W-1:0] feature_count_q;
	logic [COUNT_W-1:0] grid_rows_q;
	logic [COUNT_W-1:0] grid_cols_q;
	cfg_reg_t           reg_sel;
	logic               cfg_write;

	logic               s1_valid_q;
	logic [TOKEN_W-1:0] token_s1;
	logic [COUNT_W-1:0] length_s1;
	logic               advance;

	logic [COUNT_W-1:0] token_index_q;
	phase_t             phase_q;
	logic [COUNT_W-1:0] run_start_q;
	logic [COUNT_W-1:0] row_q;
	logic [COUNT_W-1:0] col_q;
	logic [COUNT_W-1:0] run_q;
	logic [NEXT_W-1:0]  text_pos_q;

	logic [COUNT_W-1:0]   len_c;
	logic                 last_c;
	logic [2*COUNT_W-1:0] grid_area;
	logic                 grid_ok;
	logic                 fits;
	logic                 opens;
	logic [COUNT_W-1:0]   larger;
	phase_t               eff_phase;
	logic [COUNT_W-1:0]   eff_start;
	logic [COUNT_W-1:0]   eff_row;
	logic [COUNT_W-1:0]   eff_col;
	logic [COUNT_W-1:0]   eff_run;
	logic [NEXT_W-1:0]    run_end;

	phase_t             phase_d;
	logic [COUNT_W-1:0] row_d;
	logic [COUNT_W-1:0] col_d;
	logic [COUNT_W-1:0] run_d;
	logic [NEXT_W-1:0]  text_pos_d;
	logic [TEMP_W-1:0]  temp_c;
	logic [COUNT_W-1:0] row_pos_c;
	logic [COUNT_W-1:0] col_pos_c;
	logic [NEXT_W-1:0]  next_c;

	logic                m_valid_q;
	logic [TEMP_W-1:0]   temp_q;
	logic [COUNT_W-1:0]  row_pos_q;
	logic [COUNT_W-1:0]  col_pos_q;
	logic [NEXT_W-1:0]   next_q;
	logic                last_q;

	// Configuration port.
	assign pready    = 1'b1;
	assign reg_sel   = cfg_reg_t'(paddr[ADDR_W-1:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_token_q   <= '0;
			feature_count_q <= '0;
			grid_rows_q     <= '0;
			grid_cols_q     <= '0;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_IMAGE_TOKEN:   image_token_q   <= pwdata[TOKEN_W-1:0];
				REG_FEATURE_COUNT: feature_count_q <= pwdata[COUNT_W-1:0];
				REG_GRID_ROWS:     grid_rows_q     <= pwdata[COUNT_W-1:0];
				REG_GRID_COLS:     grid_cols_q     <= pwdata[COUNT_W-1:0];
				default:           image_token_q   <= image_token_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_IMAGE_TOKEN:   prdata = {1'b0, image_token_q};
			REG_FEATURE_COUNT: prdata = {15'd0, feature_count_q};
			REG_GRID_ROWS:     prdata = {15'd0, grid_rows_q};
			REG_GRID_COLS:     prdata = {15'd0, grid_cols_q};
			default:           prdata = '0;
		endcase
	end

	// Handshake between the input register and the result register.
	assign advance  = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			token_s1  <= s_tdata[TOKEN_W-1:0];
			length_s1 <= s_tdata[TOKEN_W+COUNT_W-1:TOKEN_W];
		end
	end

	// Position logic for the token in the input register.
	always_comb begin
		if (length_s1 == '0) begin
			len_c = COUNT_W'(1);
		end else if (32'(length_s1) > 32'(MAX_TOKENS)) begin
			len_c = COUNT_W'(MAX_TOKENS);
		end else begin
			len_c = length_s1;
		end
		last_c    = ({1'b0, token_index_q} + NEXT_W'(1)) >= {1'b0, len_c};
		grid_area = {{COUNT_W{1'b0}}, grid_rows_q} * {{COUNT_W{1'b0}}, grid_cols_q};
		grid_ok   = (grid_rows_q != '0) && (grid_cols_q != '0)
			&& (grid_area == {{COUNT_W{1'b0}}, feature_count_q});
		fits      = ({1'b0, token_index_q} + {1'b0, feature_count_q}) <= {1'b0, len_c};
		opens     = (phase_q == PH_BEFORE) && (token_s1 == image_token_q);
		larger    = (grid_rows_q > grid_cols_q) ? grid_rows_q : grid_cols_q;

		eff_phase = phase_q;
		eff_start = run_start_q;
		eff_row   = row_q;
		eff_col   = col_q;
		eff_run   = run_q;
		if (opens) begin
			if (grid_ok && fits) begin
				eff_phase = PH_RUN;
				eff_start = token_index_q;
				eff_row   = '0;
				eff_col   = '0;
				eff_run   = '0;
			end else begin
				eff_phase = PH_PLAIN;
			end
		end
		run_end = {1'b0, eff_start} + {1'b0, larger};

		phase_d    = eff_phase;
		row_d      = eff_row;
		col_d      = eff_col;
		run_d      = eff_run;
		text_pos_d = text_pos_q;
		case (eff_phase)
			PH_RUN: begin
				temp_c    = eff_start[TEMP_W-1:0];
				row_pos_c = eff_start + eff_row;
				col_pos_c = eff_start + eff_col;
				next_c    = run_end;
				if (({1'b0, eff_col} + NEXT_W'(1)) >= {1'b0, grid_cols_q}) begin
					col_d = '0;
					row_d = eff_row + COUNT_W'(1);
				end else begin
					col_d = eff_col + COUNT_W'(1);
				end
				run_d = eff_run + COUNT_W'(1);
				if (run_d >= feature_count_q) begin
					phase_d    = PH_AFTER;
					text_pos_d = run_end;
				end
			end
			PH_AFTER: begin
				temp_c     = text_pos_q[TEMP_W-1:0];
				row_pos_c  = text_pos_q[COUNT_W-1:0];
				col_pos_c  = text_pos_q[COUNT_W-1:0];
				text_pos_d = text_pos_q + NEXT_W'(1);
				next_c     = text_pos_d;
			end
			default: begin
				temp_c    = token_index_q[TEMP_W-1:0];
				row_pos_c = token_index_q;
				col_pos_c = token_index_q;
				next_c    = {1'b0, token_index_q} + NEXT_W'(1);
			end
		endcase
	end

	// Sequence state, updated as each token moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_index_q <= '0;
			phase_q       <= PH_BEFORE;
			run_start_q   <= '0;
			row_q         <= '0;
			col_q         <= '0;
			run_q         <= '0;
			text_pos_q    <= '0;
		end else if (advance) begin
			if (last_c) begin
				token_index_q <= '0;
				phase_q       <= PH_BEFORE;
				run_start_q   <= '0;
				row_q         <= '0;
				col_q         <= '0;
				run_q         <= '0;
				text_pos_q    <= '0;
			end else begin
				token_index_q <= token_index_q + COUNT_W'(1);
				phase_q       <= phase_d;
				run_start_q   <= eff_start;
				row_q         <= row_d;
				col_q         <= col_d;
				run_q         <= run_d;
				text_pos_q    <= text_pos_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			temp_q    <= temp_c;
			row_pos_q <= row_pos_c;
			col_pos_q <= col_pos_c;
			next_q    <= last_c ? next_c : '0;
			last_q    <= last_c;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {4'd0, next_q, col_pos_q, row_pos_q, temp_q};

	`MRPG_ASSERT_IMP(a_ready_when_empty, !m_valid_q, s_tready)
	`MRPG_ASSERT_IMP(a_next_only_on_last, m_valid_q && !last_q, next_q == '0)
	`MRPG_ASSERT_NXT(a_clear_after_last, advance && last_c,
		token_index_q == '0 && phase_q == PH_BEFORE)
	`MRPG_ASSERT_NXT(a_index_steps, advance && !last_c,
		token_index_q == $past(token_index_q) + COUNT_W'(1))

endmodule
